// ===== src/ialu_pkg.sv =====
package ialu_pkg;

  localparam int DataWidth  = 32;
  localparam int KindWidth  = 4;
  localparam int ShiftWidth = 5;
  localparam int CountWidth = $clog2(DataWidth + 1);

  typedef logic [KindWidth-1:0] kind_t;
  typedef logic [DataWidth-1:0] word_t;

  localparam kind_t OpAdd = 4'd0;
  localparam kind_t OpSub = 4'd1;
  localparam kind_t OpMul = 4'd2;
  localparam kind_t OpDiv = 4'd3;
  localparam kind_t OpRem = 4'd4;
  localparam kind_t OpShl = 4'd5;
  localparam kind_t OpSar = 4'd6;
  localparam kind_t OpAnd = 4'd7;
  localparam kind_t OpOr  = 4'd8;
  localparam kind_t OpXor = 4'd9;
  localparam kind_t OpEq  = 4'd10;
  localparam kind_t OpNe  = 4'd11;
  localparam kind_t OpGt  = 4'd12;
  localparam kind_t OpLt  = 4'd13;
  localparam kind_t OpGe  = 4'd14;
  localparam kind_t OpLe  = 4'd15;

endpackage

// ===== src/ialu_divpipe.sv =====
// Restoring divider on magnitudes, one quotient bit per stage.
module ialu_divpipe (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  ialu_pkg::word_t          dividend,
  input  ialu_pkg::word_t          divisor,
  output logic                     out_valid,
  output ialu_pkg::word_t          quotient,
  output ialu_pkg::word_t          remainder
);
  import ialu_pkg::*;

  localparam int N = DataWidth;

  logic         vld   [1:N];
  word_t        rem_q [1:N];
  word_t        quo_q [1:N];
  word_t        dvs_q [1:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic       v_src;
    word_t      r_src;
    word_t      q_src;
    word_t      d_src;
    logic [N:0] trial;
    logic [N:0] diff;
    if (s == 0) begin : g_head
      assign v_src = in_valid;
      assign r_src = '0;
      assign q_src = dividend;
      assign d_src = divisor;
    end else begin : g_body
      assign v_src = vld[s];
      assign r_src = rem_q[s];
      assign q_src = quo_q[s];
      assign d_src = dvs_q[s];
    end
    assign trial = {r_src, q_src[N-1]};
    assign diff  = trial - {1'b0, d_src};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= v_src;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (diff[N]) begin
          rem_q[s+1] <= trial[N-1:0];
          quo_q[s+1] <= {q_src[N-2:0], 1'b0};
        end else begin
          rem_q[s+1] <= diff[N-1:0];
          quo_q[s+1] <= {q_src[N-2:0], 1'b1};
        end
      end
    end
    if (s < N - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          dvs_q[s+1] <= d_src;
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = quo_q[N];
  assign remainder = rem_q[N];
endmodule

// ===== src/integer_alu_with_compare.sv =====
// Channel | Signals                           | Direction
// in      | in_valid, in_stall, kind, operand_a, operand_b | into block
// out     | out_valid, out_stall, result, div_zero         | out of block
// One word enters per cycle while in_stall is low; every code travels alongside
// the one-bit-per-stage divider, between the input register and the output one.
// The whole pipe advances together; out_stall with a full output holds it.
// Reset clears the valid bits only; results never reorder.
module integer_alu_with_compare (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ialu_pkg::kind_t  kind,
  input  ialu_pkg::word_t  operand_a,
  input  ialu_pkg::word_t  operand_b,
  output logic             out_valid,
  input  logic             out_stall,
  output ialu_pkg::word_t  result,
  output logic             div_zero
);
  import ialu_pkg::*;

  localparam int N = DataWidth;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: register inputs
  logic  v1;
  kind_t k1;
  word_t a1, b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k1 <= kind;
      a1 <= operand_a;
      b1 <= operand_b;
    end
  end

  // stage 2: simple ops, product, magnitudes
  logic [ShiftWidth-1:0] sh;
  logic [CountWidth:0]   sh_ext;
  logic                  lt, gt, eq;
  word_t                 simple;
  assign sh     = b1[ShiftWidth-1:0];
  assign sh_ext = (CountWidth+1)'(sh);
  assign eq     = a1 == b1;
  assign lt     = $signed(a1) < $signed(b1);
  assign gt     = $signed(b1) < $signed(a1);

  always_comb begin
    case (k1)
      OpAdd: simple = a1 + b1;
      OpSub: simple = a1 - b1;
      OpShl: simple = (sh_ext >= (CountWidth+1)'(N)) ? '0 : (a1 << sh);
      OpSar: simple = (sh_ext >= (CountWidth+1)'(N)) ? {N{a1[N-1]}}
                                                     : word_t'($signed(a1) >>> sh);
      OpAnd: simple = a1 & b1;
      OpOr:  simple = a1 | b1;
      OpXor: simple = a1 ^ b1;
      OpEq:  simple = word_t'(eq);
      OpNe:  simple = word_t'(!eq);
      OpGt:  simple = word_t'(gt);
      OpLt:  simple = word_t'(lt);
      OpGe:  simple = word_t'(!lt);
      OpLe:  simple = word_t'(!gt);
      default: simple = '0;
    endcase
  end

  logic  v2, an2, bn2;
  kind_t k2;
  word_t r2, ua2, ub2, prod2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k2    <= k1;
      r2    <= simple;
      prod2 <= a1 * b1;
      an2   <= a1[N-1];
      bn2   <= b1[N-1];
      ua2   <= a1[N-1] ? -a1 : a1;
      ub2   <= b1[N-1] ? -b1 : b1;
    end
  end

  // divider stages; side data rides along
  logic  dv_valid;
  word_t quo, rmd;
  ialu_divpipe u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v2),
    .dividend(ua2), .divisor(ub2),
    .out_valid(dv_valid), .quotient(quo), .remainder(rmd)
  );

  kind_t side_k  [1:N];
  word_t side_r  [1:N];
  logic  side_an [1:N];
  logic  side_bn [1:N];
  logic  side_z  [1:N];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_k[1]  <= k2;
      side_r[1]  <= (k2 == OpMul) ? prod2 : r2;
      side_an[1] <= an2;
      side_bn[1] <= bn2;
      side_z[1]  <= ub2 == '0;
      for (int s = 1; s < N; s++) begin
        side_k[s+1]  <= side_k[s];
        side_r[s+1]  <= side_r[s];
        side_an[s+1] <= side_an[s];
        side_bn[s+1] <= side_bn[s];
        side_z[s+1]  <= side_z[s];
      end
    end
  end

  // final stage: sign fix and select
  logic  isdiv;
  word_t fin;
  assign isdiv = (side_k[N] == OpDiv) || (side_k[N] == OpRem);
  always_comb begin
    if (side_k[N] == OpDiv) begin
      fin = (side_an[N] != side_bn[N]) ? -quo : quo;
    end else begin
      fin = side_an[N] ? -rmd : rmd;
    end
    if (side_z[N]) begin
      fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      result   <= isdiv ? fin : side_r[N];
      div_zero <= isdiv && side_z[N];
    end
  end

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> result == '0) else $error("div_zero with nonzero result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result)) else $error("result lost");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
endmodule

// ===== verif/ialu_checker.sv =====
`timescale 1ns / 100ps

module ialu_checker
  import ialu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_stall,
  input  kind_t  kind,
  input  word_t  operand_a,
  input  word_t  operand_b,
  input  logic   out_valid,
  input  logic   out_stall,
  input  word_t  result,
  input  logic   div_zero,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    word_t value;
    logic  dz;
  } alu_answer_t;

  alu_answer_t answers_q[$];
  int          checked;

  assign pending = answers_q.size();

  function automatic alu_answer_t compute_alu(kind_t op, word_t a, word_t b);
    alu_answer_t ans;
    logic signed [DataWidth-1:0] sa;
    logic signed [DataWidth-1:0] sb;
    logic [ShiftWidth-1:0]       amt;
    word_t                       ua;
    word_t                       ub;
    word_t                       mag;
    sa = a;
    sb = b;
    amt = b[ShiftWidth-1:0];
    ua = sa[DataWidth-1] ? -a : a;
    ub = sb[DataWidth-1] ? -b : b;
    ans.value = '0;
    ans.dz = 1'b0;
    case (op)
      OpAdd: ans.value = a + b;
      OpSub: ans.value = a - b;
      OpMul: ans.value = a * b;
      OpDiv, OpRem: begin
        if (b == '0) begin
          ans.dz = 1'b1;
        end else if (op == OpDiv) begin
          mag = ua / ub;
          ans.value = (sa[DataWidth-1] != sb[DataWidth-1]) ? -mag : mag;
        end else begin
          mag = ua % ub;
          ans.value = sa[DataWidth-1] ? -mag : mag;
        end
      end
      OpShl: ans.value = a << amt;
      OpSar: ans.value = sa >>> amt;
      OpAnd: ans.value = a & b;
      OpOr:  ans.value = a | b;
      OpXor: ans.value = a ^ b;
      OpEq:  ans.value = word_t'(a == b);
      OpNe:  ans.value = word_t'(a != b);
      OpGt:  ans.value = word_t'(sa > sb);
      OpLt:  ans.value = word_t'(sa < sb);
      OpGe:  ans.value = word_t'(sa >= sb);
      default: ans.value = word_t'(sa <= sb);
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    alu_answer_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        answers_q.push_back(compute_alu(kind, operand_a, operand_b));
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (answers_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = answers_q.pop_front();
          if (result !== want.value) begin
            report_mismatch($sformatf("word %0d result %h, want %h",
                                      checked, result, want.value));
          end
          if (div_zero !== want.dz) begin
            report_mismatch($sformatf("word %0d div_zero %b, want %b",
                                      checked, div_zero, want.dz));
          end
        end
      end
    end
  end

  final begin
    if (answers_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", answers_q.size());
    end
  end

endmodule

// ===== verif/tb_integer_alu_with_compare.sv =====
`timescale 1ns / 100ps

module tb_integer_alu_with_compare;
  import ialu_pkg::*;

  localparam int NumRandom  = 1700;
  localparam int PipeDepth  = DataWidth + 3;
  localparam int HoldCycles = 200;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  kind_t kind = OpAdd;
  word_t operand_a = '0;
  word_t operand_b = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t result;
  logic  div_zero;
  int    fail_count;
  int    pending;
  int    sent = 0;
  bit    quiet = 1'b0;
  bit    holding = 1'b0;

  always #10 clk = ~clk;

  integer_alu_with_compare i_dut (
    .clk, .rst, .in_valid, .in_stall, .kind, .operand_a, .operand_b,
    .out_valid, .out_stall, .result, .div_zero
  );

  ialu_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .kind, .operand_a, .operand_b,
    .out_valid, .out_stall, .result, .div_zero, .fail_count, .pending
  );

  function automatic word_t pick_operand();
    case ($urandom_range(0, 7))
      0: return word_t'({1'b1, {(DataWidth-1){1'b0}}});
      1: return word_t'({1'b0, {(DataWidth-1){1'b1}}});
      2: return '1;
      3: return '0;
      4: return word_t'($urandom_range(0, 40)) - 20;
      default: return word_t'($urandom);
    endcase
  endfunction

  // offer one word, optionally after a random gap; hold until taken
  task automatic send_word(input kind_t op, input word_t a, input word_t b);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(posedge clk) begin
    if (holding) begin
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 7);
    end
  end

  initial begin
    @(posedge clk);
    wait (sent == 300);
    holding = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding = 1'b0;
  end

  initial begin
    word_t mn;
    word_t mx;
    int    wait_cycles;
    mn = word_t'({1'b1, {(DataWidth-1){1'b0}}});
    mx = ~mn;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: every code, edge operands, divide corner cases
    for (int op = 0; op < 16; op++) begin
      send_word(kind_t'(op), mn, mx);
    end
    send_word(OpDiv, 32'd7, '0);
    send_word(OpRem, mn, '0);
    send_word(OpDiv, mn, '1);
    send_word(OpRem, mn, '1);
    send_word(OpDiv, -32'sd7, 32'd2);
    send_word(OpRem, -32'sd7, 32'd2);
    send_word(OpShl, '1, 32'hFFFF_FFFF);
    send_word(OpSar, mn, 32'h0000_003F);
    send_word(OpAdd, mx, 32'd1);
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 800 && n < 1100);
      send_word(kind_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PipeDepth * 2) @(posedge clk);
    $display("Sent %0d words over all sixteen codes, with divide-by-zero,", sent);
    $display("overflow and shift corners, random gaps and a long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("integer_alu_with_compare: match");
    end else begin
      $display("integer_alu_with_compare: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("integer_alu_with_compare: mismatch");
    $finish;
  end

endmodule
